FILE: src/ps2_gamepad_poll_decoder_assert.svh
// assertion macros used by the gamepad poll decoder sequencer rtl
// expects signals clk and rst_n in the including module
`ifndef PS2_GAMEPAD_POLL_DECODER_ASSERT_SVH
`define PS2_GAMEPAD_POLL_DECODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PS2GP_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2gp: same-cycle check failed");

// next-cycle implication, disabled during reset
`define PS2GP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2gp: next-cycle check failed");

`endif

FILE: src/ps2gp_pkg.sv
// shared types and constants of the gamepad poll decoder
// no dependencies
`timescale 1ns / 1ps

package ps2gp_pkg;

    // frame geometry
    localparam int FRAME_BYTES_DEF = 9;
    localparam int STORE_DEPTH     = 9;
    localparam int STORE_IDX_W     = $clog2(STORE_DEPTH);
    localparam int QUEUE_DEPTH_DEF = 2;

    // protocol bytes
    localparam logic [7:0] CMD_START  = 8'h01;
    localparam logic [7:0] CMD_POLL   = 8'h42;
    localparam logic [7:0] CMD_FILL   = 8'hFF;
    localparam logic [7:0] HDR_OK     = 8'h5A;
    localparam logic [7:0] MODE_DIG   = 8'h41;
    localparam logic [7:0] MODE_ANA   = 8'h73;
    localparam logic [7:0] STICK_MID  = 8'h80;
    localparam logic [7:0] STICK_MAX  = 8'd127;
    localparam logic [7:0] STICK_MIN  = 8'h81;

    // configuration port
    localparam int          PADDR_W          = 3;
    localparam int          PDATA_W          = 32;
    localparam logic [0:0]  REG_DELAY_CYCLES = 1'b0;
    localparam logic [15:0] DELAY_RESET      = 16'd250;

    typedef struct packed {
        logic start_poll;
        logic data_line;
    } item_t;

    typedef struct packed {
        logic              select_pin;
        logic              clock_pin;
        logic              command_pin;
        logic              busy_res;
        logic              frame_done;
        logic [15:0]       buttons;
        logic [1:0]        stick_buttons;
        logic              analog_mode;
        logic signed [7:0] left_x;
        logic signed [7:0] left_y;
        logic signed [7:0] right_x;
        logic signed [7:0] right_y;
    } result_t;

endpackage

FILE: src/ps2gp_fifo.sv
// small register queue used on the input and result sides
// depends on nothing outside this file
`timescale 1ns / 1ps

module ps2gp_fifo #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // status
    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: src/ps2gp_engine.sv
// serial bit sequencer and frame decoder, one step per request
// depends on ps2gp_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "ps2_gamepad_poll_decoder_assert.svh"

module ps2gp_engine
    import ps2gp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] delay_cycles,
    input  logic        in_valid,
    input  item_t       in_item,
    output logic        in_take,
    input  logic        out_full,
    output logic        out_push,
    output result_t     out_res
);

    localparam int BYTE_W = $clog2(FRAME_BYTES + 1);
    localparam logic [BYTE_W-1:0] LAST_BYTE   = BYTE_W'(FRAME_BYTES - 1);
    localparam logic [BYTE_W-1:0] STORE_LIMIT = BYTE_W'(STORE_DEPTH);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_HIGH1 = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;
    localparam logic [1:0] PH_HIGH2 = 2'd3;

    logic [1:0]        phase_reg, phase_next;
    logic [15:0]       wait_count_reg, wait_count_next;
    logic [2:0]        bit_index_reg, bit_index_next;
    logic [BYTE_W-1:0] byte_index_reg, byte_index_next;
    logic [7:0]        tx_reg, tx_next;
    logic [7:0]        rx_reg, rx_next;
    logic [7:0]        frame_store_reg [STORE_DEPTH];
    logic [7:0]        store_view [STORE_DEPTH];
    logic [15:0]       held_buttons_reg, held_buttons_next;
    logic [1:0]        held_stick_buttons_reg, held_stick_buttons_next;
    logic              held_mode_reg, held_mode_next;
    logic [7:0]        held_sticks_reg [4];
    logic [7:0]        held_sticks_next [4];

    logic              step;
    logic              frame_end;
    logic              store_we;
    logic [15:0]       delay_eff;
    logic [16:0]       wait_inc;
    logic              phase_end;
    logic [7:0]        inv_b3;
    logic [7:0]        inv_b4;
    logic [15:0]       keys;

    function automatic logic [7:0] dir_value(input logic plus, input logic minus);
        logic [7:0] v;
        begin
            v = 8'd0;
            if (plus && !minus)
            begin
                v = STICK_MAX;
            end
            else if (minus && !plus)
            begin
                v = STICK_MIN;
            end
            return v;
        end
    endfunction

    // one step whenever a request is waiting and the result queue has room
    assign step     = in_valid && !out_full;
    assign in_take  = step;
    assign out_push = step;

    // phase timing
    assign delay_eff = (delay_cycles == 16'd0) ? 16'd1 : delay_cycles;
    assign wait_inc  = {1'b0, wait_count_reg} + 17'd1;
    assign phase_end = (wait_inc >= {1'b0, delay_eff});

    // bit and byte sequencing
    always_comb
    begin
        phase_next      = phase_reg;
        wait_count_next = wait_count_reg;
        bit_index_next  = bit_index_reg;
        byte_index_next = byte_index_reg;
        tx_next         = tx_reg;
        rx_next         = rx_reg;
        frame_end       = 1'b0;
        store_we        = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            if (in_item.start_poll)
            begin
                phase_next      = PH_HIGH1;
                wait_count_next = '0;
                bit_index_next  = '0;
                byte_index_next = '0;
                tx_next         = CMD_START;
                rx_next         = '0;
            end
        end
        else
        begin
            // sample data on the first cycle of clock low
            if (phase_reg == PH_LOW && wait_count_reg == 16'd0)
            begin
                rx_next = {in_item.data_line, rx_reg[7:1]};
            end
            if (!phase_end)
            begin
                wait_count_next = wait_inc[15:0];
            end
            else
            begin
                wait_count_next = '0;
                case (phase_reg)
                    PH_HIGH1:
                    begin
                        phase_next = PH_LOW;
                    end
                    PH_LOW:
                    begin
                        phase_next = PH_HIGH2;
                    end
                    default:
                    begin
                        tx_next = {1'b0, tx_reg[7:1]};
                        if (bit_index_reg != 3'd7)
                        begin
                            bit_index_next = bit_index_reg + 3'd1;
                            phase_next     = PH_HIGH1;
                        end
                        else
                        begin
                            store_we       = (byte_index_reg < STORE_LIMIT);
                            bit_index_next = '0;
                            if (byte_index_reg == LAST_BYTE)
                            begin
                                phase_next      = PH_IDLE;
                                byte_index_next = '0;
                                frame_end       = 1'b1;
                            end
                            else
                            begin
                                byte_index_next = byte_index_reg + BYTE_W'(1);
                                tx_next = (byte_index_reg == '0) ? CMD_POLL : CMD_FILL;
                                phase_next = PH_HIGH1;
                            end
                        end
                    end
                endcase
            end
        end
    end

    // frame bytes as they stand after this step's write
    always_comb
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            store_view[i] = (store_we && byte_index_reg[STORE_IDX_W-1:0] == STORE_IDX_W'(i))
                            ? rx_next : frame_store_reg[i];
        end
    end

    // button and stick decode at frame end, only behind a valid header byte
    assign inv_b3 = ~store_view[3];
    assign inv_b4 = ~store_view[4];
    assign keys   = {inv_b4, inv_b3 & 8'hF9};

    always_comb
    begin
        held_buttons_next       = held_buttons_reg;
        held_stick_buttons_next = held_stick_buttons_reg;
        held_mode_next          = held_mode_reg;
        for (int s = 0; s < 4; s++)
        begin
            held_sticks_next[s] = held_sticks_reg[s];
        end
        if (frame_end && store_view[2] == HDR_OK)
        begin
            held_buttons_next = keys;
            if (store_view[1] == MODE_DIG)
            begin
                held_mode_next      = 1'b0;
                held_sticks_next[0] = dir_value(keys[5], keys[7]);
                held_sticks_next[1] = dir_value(keys[4], keys[6]);
                held_sticks_next[2] = dir_value(keys[13], keys[15]);
                held_sticks_next[3] = dir_value(keys[12], keys[14]);
            end
            else if (store_view[1] == MODE_ANA)
            begin
                held_mode_next          = 1'b1;
                held_stick_buttons_next = inv_b3[2:1];
                held_sticks_next[0]     = store_view[7] - STICK_MID;
                held_sticks_next[1]     = STICK_MAX - store_view[8];
                held_sticks_next[2]     = store_view[5] - STICK_MID;
                held_sticks_next[3]     = STICK_MAX - store_view[6];
            end
        end
    end

    // control and held state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg              <= PH_IDLE;
            wait_count_reg         <= '0;
            bit_index_reg          <= '0;
            byte_index_reg         <= '0;
            tx_reg                 <= '0;
            rx_reg                 <= '0;
            held_buttons_reg       <= '0;
            held_stick_buttons_reg <= '0;
            held_mode_reg          <= 1'b0;
            for (int s = 0; s < 4; s++)
            begin
                held_sticks_reg[s] <= '0;
            end
        end
        else if (step)
        begin
            phase_reg              <= phase_next;
            wait_count_reg         <= wait_count_next;
            bit_index_reg          <= bit_index_next;
            byte_index_reg         <= byte_index_next;
            tx_reg                 <= tx_next;
            rx_reg                 <= rx_next;
            held_buttons_reg       <= held_buttons_next;
            held_stick_buttons_reg <= held_stick_buttons_next;
            held_mode_reg          <= held_mode_next;
            for (int s = 0; s < 4; s++)
            begin
                held_sticks_reg[s] <= held_sticks_next[s];
            end
        end
    end

    // received frame bytes
    always_ff @(posedge clk)
    begin
        if (step && store_we)
        begin
            frame_store_reg[byte_index_reg[STORE_IDX_W-1:0]] <= rx_next;
        end
    end

    // result of this step
    always_comb
    begin
        if (phase_next == PH_IDLE)
        begin
            out_res.select_pin  = 1'b1;
            out_res.clock_pin   = 1'b1;
            out_res.command_pin = 1'b1;
            out_res.busy_res    = 1'b0;
        end
        else
        begin
            out_res.select_pin  = 1'b0;
            out_res.clock_pin   = (phase_next != PH_LOW);
            out_res.command_pin = tx_next[0];
            out_res.busy_res    = 1'b1;
        end
        out_res.frame_done    = frame_end;
        out_res.buttons       = held_buttons_next;
        out_res.stick_buttons = held_stick_buttons_next;
        out_res.analog_mode   = held_mode_next;
        out_res.left_x        = $signed(held_sticks_next[0]);
        out_res.left_y        = $signed(held_sticks_next[1]);
        out_res.right_x       = $signed(held_sticks_next[2]);
        out_res.right_y       = $signed(held_sticks_next[3]);
    end

    // checks
    `PS2GP_ASSERT_NEXT(a_done_goes_idle, step && frame_end, phase_reg == PH_IDLE)
    `PS2GP_ASSERT_IMPLIES(a_idle_counters_clear, phase_reg == PH_IDLE,
        wait_count_reg == '0 && bit_index_reg == '0 && byte_index_reg == '0)
    `PS2GP_ASSERT_NEXT(a_stall_holds_state, !step,
        $stable(phase_reg) && $stable(wait_count_reg) && $stable(rx_reg))

endmodule

FILE: src/ps2_gamepad_poll_decoder.sv
// gamepad poll decoder: one result per request; on its way to the result ports
// a request passes the input queue, then the sequencer step
// throughput one request per cycle while the result queue has room
// the serial frame spans FRAME_BYTES * 8 * 3 * max(delay_cycles, 1) requests
// rst_n clears the queues, sequencer, held decode and sets delay_cycles to 250
`timescale 1ns / 1ps

module ps2_gamepad_poll_decoder
    import ps2gp_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // request side
    input  logic               push,
    output logic               full,
    input  item_t              item,
    // result side
    output logic               empty,
    input  logic               pop,
    output result_t            result,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [15:0]            delay_cycles_reg, delay_cycles_next;
    logic                   cfg_write;
    logic                   sel_delay;
    logic [$bits(item_t)-1:0]   in_q_data;
    logic [$bits(result_t)-1:0] out_q_data;
    logic                   in_q_empty;
    logic                   in_take;
    logic                   out_full;
    logic                   out_push;
    result_t                step_res;

    // register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign sel_delay = (paddr[PADDR_W-1:2] == REG_DELAY_CYCLES);
    assign prdata    = sel_delay ? {16'd0, delay_cycles_reg} : '0;
    assign delay_cycles_next = (cfg_write && sel_delay) ? pwdata[15:0] : delay_cycles_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_cycles_reg <= DELAY_RESET;
        end
        else
        begin
            delay_cycles_reg <= delay_cycles_next;
        end
    end

    // front: request queue
    ps2gp_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_in_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (item),
        .full  (full),
        .pop   (in_take),
        .rdata (in_q_data),
        .empty (in_q_empty)
    );

    // back: sequencer and decoder
    ps2gp_engine #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .delay_cycles (delay_cycles_reg),
        .in_valid     (!in_q_empty),
        .in_item      (item_t'(in_q_data)),
        .in_take      (in_take),
        .out_full     (out_full),
        .out_push     (out_push),
        .out_res      (step_res)
    );

    // result queue
    ps2gp_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (step_res),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_q_data),
        .empty (empty)
    );

    assign result = result_t'(out_q_data);

endmodule

FILE: bench/ps2_gamepad_poll_checker.sv
// result checker for the gamepad poll decoder: predicts each request's pin and decode outputs
// and compares them in order with the results popped from the block
// depends on ps2gp_pkg for the request and result types and protocol constants
`timescale 1ns / 1ps

module ps2_gamepad_poll_checker
    import ps2gp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  item_t              item,
    input  logic               pop,
    input  logic               empty,
    input  result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               checks_done,
    output int                 mismatches
);

    localparam logic [PADDR_W-1:0] DELAY_ADDR = PADDR_W'(4 * REG_DELAY_CYCLES);

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_CLK_HIGH,
        SEQ_CLK_LOW,
        SEQ_CLK_RETURN
    } seq_phase_e;

    // predicted sequencer and decode state
    seq_phase_e        phase;
    logic [15:0]       cfg_delay;
    logic [15:0]       wait_cnt;
    logic [2:0]        bit_cnt;
    int                byte_cnt;
    logic [7:0]        tx_shift;
    logic [7:0]        rx_shift;
    logic [7:0]        rx_bytes [STORE_DEPTH];
    logic [15:0]       held_buttons;
    logic [1:0]        held_stick_btn;
    logic              held_analog;
    logic signed [7:0] held_stick [4];

    result_t due_outputs [$];
    int      fail_count = 0;
    int      n_checked = 0;
    bit      leftovers_reported = 1'b0;

    assign mismatches = fail_count;

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s of result %0d: expected %0h, got %0h",
                                      name, n_checked, want, got));
    endtask

    // digital stick image from one pair of opposing pad buttons
    function automatic logic signed [7:0] axis_level(input logic plus, input logic minus);
        if (plus && !minus)
            return STICK_MAX;
        if (minus && !plus)
            return STICK_MIN;
        return '0;
    endfunction

    // one step of the poll sequencer for one request, then the outputs it shows
    task automatic poll_step(input item_t it, output result_t r);
        logic [16:0] span;
        logic        done;
        logic [7:0]  inv3;
        logic [7:0]  inv4;
        logic [15:0] keys;
        span = (cfg_delay == '0) ? 17'd1 : {1'b0, cfg_delay};
        done = 1'b0;
        if (phase == SEQ_IDLE)
        begin
            if (it.start_poll)
            begin
                phase    = SEQ_CLK_HIGH;
                wait_cnt = '0;
                bit_cnt  = '0;
                byte_cnt = 0;
                tx_shift = CMD_START;
                rx_shift = '0;
            end
        end
        else
        begin
            // data line is taken on the first cycle of clock low
            if (phase == SEQ_CLK_LOW && wait_cnt == '0)
                rx_shift = {it.data_line, rx_shift[7:1]};
            if ({1'b0, wait_cnt} + 17'd1 < span)
                wait_cnt = wait_cnt + 16'd1;
            else
            begin
                wait_cnt = '0;
                case (phase)
                    SEQ_CLK_HIGH: phase = SEQ_CLK_LOW;
                    SEQ_CLK_LOW:  phase = SEQ_CLK_RETURN;
                    default:
                    begin
                        tx_shift = tx_shift >> 1;
                        if (bit_cnt != 3'd7)
                        begin
                            bit_cnt = bit_cnt + 3'd1;
                            phase   = SEQ_CLK_HIGH;
                        end
                        else
                        begin
                            if (byte_cnt < STORE_DEPTH)
                                rx_bytes[byte_cnt] = rx_shift;
                            byte_cnt = byte_cnt + 1;
                            bit_cnt  = '0;
                            if (byte_cnt >= FRAME_BYTES_DEF)
                            begin
                                phase    = SEQ_IDLE;
                                byte_cnt = 0;
                                done     = 1'b1;
                                // decode only behind a valid header byte
                                if (rx_bytes[2] == HDR_OK)
                                begin
                                    inv3 = ~rx_bytes[3];
                                    inv4 = ~rx_bytes[4];
                                    keys = {inv4, inv3 & 8'hF9};
                                    held_buttons = keys;
                                    if (rx_bytes[1] == MODE_DIG)
                                    begin
                                        held_analog   = 1'b0;
                                        held_stick[0] = axis_level(keys[5], keys[7]);
                                        held_stick[1] = axis_level(keys[4], keys[6]);
                                        held_stick[2] = axis_level(keys[13], keys[15]);
                                        held_stick[3] = axis_level(keys[12], keys[14]);
                                    end
                                    else if (rx_bytes[1] == MODE_ANA)
                                    begin
                                        held_analog    = 1'b1;
                                        held_stick_btn = inv3[2:1];
                                        held_stick[0]  = rx_bytes[7] - STICK_MID;
                                        held_stick[1]  = STICK_MAX - rx_bytes[8];
                                        held_stick[2]  = rx_bytes[5] - STICK_MID;
                                        held_stick[3]  = STICK_MAX - rx_bytes[6];
                                    end
                                end
                            end
                            else
                            begin
                                tx_shift = (byte_cnt == 1) ? CMD_POLL : CMD_FILL;
                                phase    = SEQ_CLK_HIGH;
                            end
                        end
                    end
                endcase
            end
        end
        r.select_pin    = (phase == SEQ_IDLE);
        r.clock_pin     = (phase != SEQ_CLK_LOW);
        r.command_pin   = (phase == SEQ_IDLE) ? 1'b1 : tx_shift[0];
        r.busy_res      = (phase != SEQ_IDLE);
        r.frame_done    = done;
        r.buttons       = held_buttons;
        r.stick_buttons = held_stick_btn;
        r.analog_mode   = held_analog;
        r.left_x        = held_stick[0];
        r.left_y        = held_stick[1];
        r.right_x       = held_stick[2];
        r.right_y       = held_stick[3];
    endtask

    // watch the request, result and register channels
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t fresh;
        result_t want;
        if (!rst_n)
        begin
            phase          = SEQ_IDLE;
            cfg_delay      = DELAY_RESET;
            wait_cnt       = '0;
            bit_cnt        = '0;
            byte_cnt       = 0;
            tx_shift       = '0;
            rx_shift       = '0;
            held_buttons   = '0;
            held_stick_btn = '0;
            held_analog    = 1'b0;
            for (int i = 0; i < 4; i++)
                held_stick[i] = '0;
            due_outputs.delete();
        end
        else
        begin
            // compare before predicting, a result never belongs to a same-cycle request
            if (pop && !empty)
            begin
                if (due_outputs.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              n_checked));
                else
                begin
                    want = due_outputs.pop_front();
                    check_field("select_pin", 16'(want.select_pin), 16'(result.select_pin));
                    check_field("clock_pin", 16'(want.clock_pin), 16'(result.clock_pin));
                    check_field("command_pin", 16'(want.command_pin),
                                16'(result.command_pin));
                    check_field("busy_res", 16'(want.busy_res), 16'(result.busy_res));
                    check_field("frame_done", 16'(want.frame_done), 16'(result.frame_done));
                    check_field("buttons", want.buttons, result.buttons);
                    check_field("stick_buttons", 16'(want.stick_buttons),
                                16'(result.stick_buttons));
                    check_field("analog_mode", 16'(want.analog_mode),
                                16'(result.analog_mode));
                    check_field("left_x", 16'(want.left_x), 16'(result.left_x));
                    check_field("left_y", 16'(want.left_y), 16'(result.left_y));
                    check_field("right_x", 16'(want.right_x), 16'(result.right_x));
                    check_field("right_y", 16'(want.right_y), 16'(result.right_y));
                end
                n_checked++;
            end
            if (psel && penable && pwrite && pready && paddr == DELAY_ADDR)
                cfg_delay = pwdata[15:0];
            if (push && !full)
            begin
                poll_step(item, fresh);
                due_outputs.push_back(fresh);
            end
            if (checks_done && !leftovers_reported)
            begin
                leftovers_reported = 1'b1;
                if (due_outputs.size() != 0)
                    report_mismatch($sformatf("%0d expected results never arrived",
                                              due_outputs.size()));
            end
        end
    end

endmodule

FILE: bench/tb.sv
// testbench top for the gamepad poll decoder: drives serial frames, register writes
// and random handshake gaps, and gives the verdict from the checker's mismatch count
// depends on ps2gp_pkg, ps2_gamepad_poll_decoder and ps2_gamepad_poll_checker
`timescale 1ns / 1ps

module tb;
    import ps2gp_pkg::*;

    localparam int GAP_MAX       = 18;
    localparam int HOLD_AFTER    = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 8;
    localparam int RANDOM_FRAMES = 1;
    localparam int RECOVER_ITEMS = 230;

    localparam logic [PADDR_W-1:0] DELAY_ADDR = PADDR_W'(4 * REG_DELAY_CYCLES);

    typedef logic [FRAME_BYTES_DEF-1:0][7:0] frame_bytes_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               push;
    logic               full;
    item_t              item;
    logic               empty;
    logic               pop;
    result_t            result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               checks_done;
    int                 mismatches;

    int          n_pushed = 0;
    int          n_popped = 0;
    int          idle_cycles = 0;
    bit          send_eager = 1'b0;
    bit          take_eager = 1'b0;
    logic [15:0] cur_delay;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ps2_gamepad_poll_decoder u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ps2_gamepad_poll_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .pop         (pop),
        .empty       (empty),
        .result      (result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .checks_done (checks_done),
        .mismatches  (mismatches)
    );

    function automatic int draw_gap(input bit eager);
        return eager ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    // offer one request and wait until it is taken
    task automatic send_item(input logic start, input logic data);
        int gap;
        gap = draw_gap(send_eager);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= '{start_poll: start, data_line: data};
        push <= 1'b1;
        do @(posedge clk); while (full);
        n_pushed++;
    endtask

    task automatic send_idle(input int n, input bit random_start);
        for (int i = 0; i < n; i++)
            send_item(random_start ? 1'($urandom) : 1'b0, 1'($urandom));
    endtask

    // register write once every result has drained
    task automatic write_delay(input logic [15:0] value);
        push <= 1'b0;
        while (n_popped != n_pushed) @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= DELAY_ADDR;
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_delay = value;
    endtask

    function automatic frame_bytes_t pad_frame(input logic [7:0] mode, input logic [7:0] hdr,
                                               input logic [7:0] b3, input logic [7:0] b4,
                                               input logic [7:0] b5, input logic [7:0] b6,
                                               input logic [7:0] b7, input logic [7:0] b8);
        return {b8, b7, b6, b5, b4, b3, hdr, mode, 8'($urandom)};
    endfunction

    // mostly well-formed frames, some with a broken header or unknown mode
    function automatic frame_bytes_t random_frame();
        logic [7:0] mode;
        logic [7:0] hdr;
        int         pick;
        pick = $urandom_range(0, 9);
        mode = (pick < 4) ? MODE_DIG : (pick < 8) ? MODE_ANA : 8'($urandom);
        hdr  = ($urandom_range(0, 4) == 0) ? 8'($urandom) : HDR_OK;
        return pad_frame(mode, hdr, 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // a full poll from idle; each bit's level sits on the clock-low sample cycle,
    // noise everywhere else and stray start requests while busy
    task automatic send_frame(input frame_bytes_t fb);
        int span;
        span = (cur_delay == '0) ? 1 : int'(cur_delay);
        send_eager = ($urandom_range(0, 3) == 0);
        send_item(1'b1, 1'($urandom));
        for (int j = 0; j < FRAME_BYTES_DEF; j++)
            for (int k = 0; k < 8; k++)
                for (int c = 0; c < 3 * span; c++)
                    send_item(1'($urandom), (c == span) ? fb[j][k] : 1'($urandom));
    endtask

    // part of a slow frame, then finish it quickly with the delay set to one
    task automatic delay_excursion(input bit do_write, input logic [15:0] big, input int n);
        if (do_write)
            write_delay(big);
        send_item(1'b1, 1'($urandom));
        send_idle(n, 1'b1);
        write_delay(16'd1);
        send_idle(RECOVER_ITEMS, 1'b0);
    endtask

    // result side, with one long hold-off to fill the block
    initial
    begin : result_side
        int gap;
        bit held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && n_popped >= HOLD_AFTER)
            begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (n_popped % 64 == 0)
                take_eager = ($urandom_range(0, 3) == 0);
            gap = draw_gap(take_eager);
            if (gap != 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            n_popped++;
        end
    end

    // watchdog on cycles with no request or result taken
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n       <= 1'b0;
        push        <= 1'b0;
        item        <= '0;
        pop         <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        checks_done <= 1'b0;
        cur_delay   = DELAY_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset outputs, then a frame started at the reset delay
        send_idle(3, 1'b0);
        delay_excursion(1'b0, DELAY_RESET, 20);

        // digital mode: up and right on both pads
        send_frame(pad_frame(MODE_DIG, HDR_OK, 8'hCF, 8'hCF, 8'h12, 8'h34, 8'h56, 8'h78));
        // zero delay acts as a delay of one; analog mode with stick presses
        write_delay(16'd0);
        send_frame(pad_frame(MODE_ANA, HDR_OK, 8'hF9, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        // broken header keeps everything
        write_delay(16'd1);
        send_frame(pad_frame(MODE_DIG, 8'h5B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

        // RANDOM_FRAMES random frames across delay settings
        for (int f = 0; f < RANDOM_FRAMES; f++)
        begin
            case ($urandom_range(0, 9))
                0:       delay_excursion(1'b1, 16'($urandom_range(256, 65535)),
                                         $urandom_range(20, 60));
                1, 2:    write_delay(16'($urandom_range(0, 1)));
                default: ;
            endcase
            send_idle($urandom_range(0, 6), 1'b0);
            send_frame(random_frame());
        end

        // drain, let the pipeline settle, then the verdict
        push <= 1'b0;
        while (n_popped != n_pushed) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        checks_done <= 1'b1;
        repeat (2) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
